>>> hw/rtl/lossless_bitmap_pixel_unpack_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap pixel unpacker
// Concurrent checks, clocked on the rising edge and idle during reset.
// ----------------------------------------------------------------------------
`ifndef LOSSLESS_BITMAP_PIXEL_UNPACK_ASSERT_SVH
`define LOSSLESS_BITMAP_PIXEL_UNPACK_ASSERT_SVH

// same-cycle implication
`define LBPU_ASSERT_IMP(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("lbpu check failed");

// next-cycle implication
`define LBPU_ASSERT_NXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("lbpu check failed");

`endif

>>> hw/rtl/lbpu_pkg.sv
// ----------------------------------------------------------------------------
// lbpu_pkg
// Shared constants, codes and types of the bitmap pixel unpacker.
// ----------------------------------------------------------------------------
package lbpu_pkg;

    localparam int PAL_DEPTH   = 256;
    localparam int PAL_IDX_W   = $clog2(PAL_DEPTH);
    localparam int DIM_BITS    = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT_VERSION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_LAST   = 3'd4;

    // pixel format codes
    localparam logic [7:0] FMT_PALETTE = 8'd3;
    localparam logic [7:0] FMT_RGB15   = 8'd4;
    localparam logic [7:0] FMT_ARGB32  = 8'd5;

    localparam logic [1:0] VERSION_ALPHA = 2'd2;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

    typedef enum logic [1:0] {
        OP_PAL_WRITE,
        OP_LOOKUP,
        OP_DIRECT
    } op_kind_t;

    // one unit of work handed from front to back
    typedef struct packed {
        op_kind_t               kind;
        logic [PAL_IDX_W-1:0]   idx;        // palette entry (write) or index (lookup)
        logic                   hit;        // lookup index within palette
        logic                   with_alpha;
        logic                   last;
        logic [31:0]            data;       // R,G,B,A from msb down
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> hw/rtl/lbpu_queue.sv
// ----------------------------------------------------------------------------
// lbpu_queue
// Short op queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
`include "lossless_bitmap_pixel_unpack_assert.svh"

module lbpu_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lbpu_pkg::op_t          push_op,
    input  logic                   pop,
    output lbpu_pkg::op_t          pop_op,
    output lbpu_pkg::queue_status_t status
);

    lbpu_pkg::op_t                           entries_reg [lbpu_pkg::QUEUE_DEPTH];
    logic [lbpu_pkg::QUEUE_PTR_W-1:0]        wr_ptr_reg;
    logic [lbpu_pkg::QUEUE_PTR_W-1:0]        rd_ptr_reg;
    logic [lbpu_pkg::QUEUE_CNT_W-1:0]        count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_op       = entries_reg[rd_ptr_reg];
    assign status.full  = (count_reg == lbpu_pkg::QUEUE_CNT_W'(lbpu_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    `LBPU_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !status.full)
    `LBPU_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !status.empty)
    `LBPU_ASSERT_NXT(a_count_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

>>> hw/rtl/lbpu_front.sv
// ----------------------------------------------------------------------------
// lbpu_front
// Config registers, stream counters and byte classification into ops.
// ----------------------------------------------------------------------------
module lbpu_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [lbpu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lbpu_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           data_byte,
    output logic                                 push,
    output lbpu_pkg::op_t                        push_op,
    input  lbpu_pkg::queue_status_t              q_status
);

    localparam int DW = lbpu_pkg::DIM_BITS;

    logic [1:0]    version_reg;
    logic [7:0]    format_reg;
    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;
    logic [7:0]    pal_last_reg;

    logic [8:0]    entry_cnt_reg, entry_cnt_next;   // palette entries loaded
    logic [DW-1:0] col_reg, col_next;
    logic [DW-1:0] row_reg, row_next;
    logic [1:0]    phase_reg, phase_next;
    logic [23:0]   asm_reg, asm_next;
    logic          done_reg, done_next;

    logic          accept;
    logic          cfg_hit;
    logic          with_alpha;
    logic          active;
    logic [DW:0]   col_inc;
    logic [DW:0]   pad4;
    logic [DW:0]   pad2;
    logic [DW:0]   padded;
    logic          visible;
    logic          is_last;
    logic [1:0]    bpe_m1;
    logic [31:0]   word;

    assign in_stall   = q_status.full;
    assign accept     = in_valid && !q_status.full;
    assign with_alpha = (version_reg == lbpu_pkg::VERSION_ALPHA);
    assign active     = !done_reg && (width_reg != '0) && (height_reg != '0);
    assign cfg_hit    = cfg_write_en && (cfg_index <= lbpu_pkg::CFG_PALETTE_LAST);

    // slot geometry
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign pad4    = ({1'b0, width_reg} + (DW+1)'(3)) & ~(DW+1)'(3);
    assign pad2    = ({1'b0, width_reg} + (DW+1)'(1)) & ~(DW+1)'(1);
    assign visible = (col_reg < width_reg);
    assign is_last = visible && (row_reg == height_reg - 1'b1)
                     && (col_reg == width_reg - 1'b1);
    assign bpe_m1  = with_alpha ? 2'd3 : 2'd2;

    always_comb
    begin
        entry_cnt_next = entry_cnt_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        phase_next     = phase_reg;
        asm_next       = asm_reg;
        done_next      = done_reg;
        push           = 1'b0;
        push_op        = '0;
        padded         = {1'b0, width_reg};
        word           = '0;
        push_op.with_alpha = with_alpha;

        if (accept && active)
        begin
            unique case (format_reg)
                lbpu_pkg::FMT_PALETTE:
                begin
                    padded = pad4;
                    if (entry_cnt_reg <= {1'b0, pal_last_reg})
                    begin
                        if (phase_reg < bpe_m1)
                        begin
                            asm_next   = {asm_reg[15:0], data_byte};
                            phase_next = phase_reg + 1'b1;
                        end
                        else
                        begin
                            word = with_alpha ? {asm_reg, data_byte}
                                              : {asm_reg[15:0], data_byte, lbpu_pkg::ALPHA_OPAQUE};
                            if (entry_cnt_reg < 9'(lbpu_pkg::PAL_DEPTH))
                            begin
                                push         = 1'b1;
                                push_op.kind = lbpu_pkg::OP_PAL_WRITE;
                                push_op.idx  = entry_cnt_reg[lbpu_pkg::PAL_IDX_W-1:0];
                                push_op.data = word;
                            end
                            asm_next       = '0;
                            phase_next     = '0;
                            entry_cnt_next = entry_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = (col_inc >= padded) ? '0 : col_inc[DW-1:0];
                        row_next = (col_inc >= padded) ? row_reg + 1'b1 : row_reg;
                        if (is_last)
                        begin
                            done_next = 1'b1;
                        end
                        if (visible)
                        begin
                            push         = 1'b1;
                            push_op.kind = lbpu_pkg::OP_LOOKUP;
                            push_op.idx  = data_byte[lbpu_pkg::PAL_IDX_W-1:0];
                            push_op.hit  = (data_byte <= pal_last_reg)
                                           && ({1'b0, data_byte} < 9'(lbpu_pkg::PAL_DEPTH));
                            push_op.last = is_last;
                        end
                    end
                end
                lbpu_pkg::FMT_RGB15:
                begin
                    padded = pad2;
                    if (!with_alpha)
                    begin
                        if (phase_reg == '0)
                        begin
                            asm_next   = {16'h0, data_byte};
                            phase_next = 2'd1;
                        end
                        else
                        begin
                            word       = {16'h0, asm_reg[7:0], data_byte};
                            asm_next   = '0;
                            phase_next = '0;
                            col_next   = (col_inc >= padded) ? '0 : col_inc[DW-1:0];
                            row_next   = (col_inc >= padded) ? row_reg + 1'b1 : row_reg;
                            if (is_last)
                            begin
                                done_next = 1'b1;
                            end
                            if (visible)
                            begin
                                push         = 1'b1;
                                push_op.kind = lbpu_pkg::OP_DIRECT;
                                push_op.last = is_last;
                                // 5-bit channels passed through without scaling
                                push_op.data = {3'b000, word[14:10], 3'b000, word[9:5],
                                                3'b000, word[4:0], lbpu_pkg::ALPHA_OPAQUE};
                            end
                        end
                    end
                end
                lbpu_pkg::FMT_ARGB32:
                begin
                    if (phase_reg != 2'd3)
                    begin
                        asm_next   = {asm_reg[15:0], data_byte};
                        phase_next = phase_reg + 1'b1;
                    end
                    else
                    begin
                        word       = {asm_reg, data_byte};
                        asm_next   = '0;
                        phase_next = '0;
                        col_next   = (col_inc >= padded) ? '0 : col_inc[DW-1:0];
                        row_next   = (col_inc >= padded) ? row_reg + 1'b1 : row_reg;
                        if (is_last)
                        begin
                            done_next = 1'b1;
                        end
                        if (visible)
                        begin
                            push         = 1'b1;
                            push_op.kind = lbpu_pkg::OP_DIRECT;
                            push_op.last = is_last;
                            push_op.data = {word[23:0],
                                            with_alpha ? word[31:24] : lbpu_pkg::ALPHA_OPAQUE};
                        end
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end

        // any register write restarts the stream
        if (cfg_hit)
        begin
            entry_cnt_next = '0;
            col_next       = '0;
            row_next       = '0;
            phase_next     = '0;
            asm_next       = '0;
            done_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg   <= 2'd1;
            format_reg    <= lbpu_pkg::FMT_PALETTE;
            width_reg     <= DW'(1);
            height_reg    <= DW'(1);
            pal_last_reg  <= '0;
            entry_cnt_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            phase_reg     <= '0;
            asm_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            entry_cnt_reg <= entry_cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            phase_reg     <= phase_next;
            asm_reg       <= asm_next;
            done_reg      <= done_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    lbpu_pkg::CFG_FORMAT_VERSION: version_reg  <= cfg_data[1:0];
                    lbpu_pkg::CFG_PIXEL_FORMAT:   format_reg   <= cfg_data[7:0];
                    lbpu_pkg::CFG_IMAGE_WIDTH:    width_reg    <= cfg_data[DW-1:0];
                    lbpu_pkg::CFG_IMAGE_HEIGHT:   height_reg   <= cfg_data[DW-1:0];
                    lbpu_pkg::CFG_PALETTE_LAST:   pal_last_reg <= cfg_data[7:0];
                    default:                      version_reg  <= version_reg;
                endcase
            end
        end
    end

endmodule

>>> hw/rtl/lbpu_back.sv
// ----------------------------------------------------------------------------
// lbpu_back
// Palette store, lookup pipeline and output register.
// ----------------------------------------------------------------------------
module lbpu_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lbpu_pkg::queue_status_t q_status,
    input  lbpu_pkg::op_t           pop_op,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue,
    output logic [7:0]              alpha,
    output logic                    last_pixel
);

    logic [31:0]                  pal_mem [lbpu_pkg::PAL_DEPTH];
    logic [lbpu_pkg::PAL_DEPTH-1:0] pal_valid_reg;   // unwritten entries read zero

    logic          s2_valid_reg;
    lbpu_pkg::op_t s2_op_reg;
    logic          s2_hit_reg;
    logic [31:0]   rd_data_reg;

    logic          out_valid_reg;
    logic [31:0]   out_word_reg;
    logic          out_last_reg;

    logic          out_ready;
    logic          s2_ready;
    logic          pop_write;
    logic [31:0]   s2_word;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign pop       = !q_status.empty && s2_ready;
    assign pop_write = pop && (pop_op.kind == lbpu_pkg::OP_PAL_WRITE);

    // palette memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (pop_write)
        begin
            pal_mem[pop_op.idx] <= pop_op.data;
        end
        if (pop)
        begin
            rd_data_reg <= pal_mem[pop_op.idx];
            s2_op_reg   <= pop_op;
            s2_hit_reg  <= pop_op.hit && pal_valid_reg[pop_op.idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= '0;
        end
        else if (pop_write)
        begin
            pal_valid_reg[pop_op.idx] <= 1'b1;
        end
    end

    always_comb
    begin
        s2_word = s2_op_reg.data;
        if (s2_op_reg.kind == lbpu_pkg::OP_LOOKUP)
        begin
            s2_word = s2_hit_reg ? rd_data_reg : '0;
            if (!s2_op_reg.with_alpha)
            begin
                s2_word[7:0] = lbpu_pkg::ALPHA_OPAQUE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= pop && (pop_op.kind != lbpu_pkg::OP_PAL_WRITE);
            end
            if (out_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            out_word_reg <= s2_word;
            out_last_reg <= s2_op_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = out_word_reg[31:24];
    assign green      = out_word_reg[23:16];
    assign blue       = out_word_reg[15:8];
    assign alpha      = out_word_reg[7:0];
    assign last_pixel = out_last_reg;

endmodule

>>> hw/rtl/lossless_bitmap_pixel_unpack.sv
// ----------------------------------------------------------------------------
// lossless_bitmap_pixel_unpack - bitmap byte stream to RGBA pixels
// Path: a byte that completes a pixel passes the op queue, the read stage and the output register before out_valid.
// Throughput: one byte per cycle while the op queue is not full.
// Reset: async active low; registers 1,3,1,1,0, counters and palette valid bits clear.
// ----------------------------------------------------------------------------
module lossless_bitmap_pixel_unpack
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_write_en,
    input  logic [lbpu_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lbpu_pkg::CFG_DATA_W-1:0]  cfg_data,
    // byte input
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       data_byte,
    // pixel output
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       red,
    output logic [7:0]                       green,
    output logic [7:0]                       blue,
    output logic [7:0]                       alpha,
    output logic                             last_pixel
);

    // Front: holds the registers and stream counters, and turns every byte
    // transfer into at most one op (palette write, palette lookup, or a
    // finished pixel). Padding bytes and bytes past the image make no op.
    // Input stalls only when the op queue is full.
    lbpu_pkg::op_t           push_op;
    lbpu_pkg::op_t           pop_op;
    lbpu_pkg::queue_status_t q_status;
    logic                    push;
    logic                    pop;

    lbpu_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .push         (push),
        .push_op      (push_op),
        .q_status     (q_status)
    );

    // Queue lets the front keep taking bytes while the output is stalled.
    lbpu_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .status  (q_status)
    );

    // Back: executes ops in order. Palette writes and lookups share the
    // store, so a lookup always sees every write queued before it. Lookups
    // take a registered read stage, then land in the output register.
    lbpu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_op     (pop_op),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .last_pixel (last_pixel)
    );

endmodule
